@@ hdl/assert_macros.svh @@
// Assertion helpers; each expects clk_i and rst_ni in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, prop, msg)

`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

@@ hdl/rssm_pkg.sv @@
`default_nettype none

package rssm_pkg;

  localparam int unsigned TimerBitsDefault = 20;
  localparam int unsigned TimeoutW         = 20;
  localparam int unsigned StateW           = 4;
  localparam int unsigned CmdW             = 5;
  localparam int unsigned ErrW             = 8;
  localparam int unsigned SafetyW          = 2;

  localparam logic [TimeoutW-1:0] HomingTimeoutReset = TimeoutW'(60000);

  // command codes
  localparam logic [CmdW-1:0] CmdInitComplete    = 5'd0;
  localparam logic [CmdW-1:0] CmdEnableRequest   = 5'd1;
  localparam logic [CmdW-1:0] CmdDisableRequest  = 5'd2;
  localparam logic [CmdW-1:0] CmdHomeRequest     = 5'd3;
  localparam logic [CmdW-1:0] CmdHomeComplete    = 5'd4;
  localparam logic [CmdW-1:0] CmdHomeError       = 5'd5;
  localparam logic [CmdW-1:0] CmdMotionStart     = 5'd6;
  localparam logic [CmdW-1:0] CmdMotionComplete  = 5'd7;
  localparam logic [CmdW-1:0] CmdMotionError     = 5'd8;
  localparam logic [CmdW-1:0] CmdProgramStart    = 5'd9;
  localparam logic [CmdW-1:0] CmdProgramPause    = 5'd10;
  localparam logic [CmdW-1:0] CmdProgramResume   = 5'd11;
  localparam logic [CmdW-1:0] CmdProgramStop     = 5'd12;
  localparam logic [CmdW-1:0] CmdProgramComplete = 5'd13;
  localparam logic [CmdW-1:0] CmdProgramError    = 5'd14;
  localparam logic [CmdW-1:0] CmdEstopPressed    = 5'd15;
  localparam logic [CmdW-1:0] CmdEstopReleased   = 5'd16;
  localparam logic [CmdW-1:0] CmdDoorOpen        = 5'd17;
  localparam logic [CmdW-1:0] CmdResetRequest    = 5'd18;
  localparam logic [CmdW-1:0] CmdErrorCleared    = 5'd19;
  localparam logic [CmdW-1:0] CmdEnable          = 5'd20;
  localparam logic [CmdW-1:0] CmdDisable         = 5'd21;
  localparam logic [CmdW-1:0] CmdReset           = 5'd22;
  localparam logic [CmdW-1:0] CmdSetMode         = 5'd23;
  localparam logic [CmdW-1:0] CmdSetError        = 5'd24;
  localparam logic [CmdW-1:0] CmdClearError      = 5'd25;
  localparam logic [CmdW-1:0] CmdTick            = 5'd26;

  // safety states
  localparam logic [SafetyW-1:0] SafeNormal = 2'd0;
  localparam logic [SafetyW-1:0] SafeProt   = 2'd1;
  localparam logic [SafetyW-1:0] SafeEmerg  = 2'd2;

  // error codes
  localparam logic [ErrW-1:0] ErrNone          = 8'd0;
  localparam logic [ErrW-1:0] ErrEstop         = 8'd1;
  localparam logic [ErrW-1:0] ErrDoorOpen      = 8'd2;
  localparam logic [ErrW-1:0] ErrHomingTimeout = 8'd3;

  localparam logic ModeManual = 1'b0;
  localparam logic ModeAuto   = 1'b1;

endpackage

`default_nettype wire

@@ hdl/rssm_if.sv @@
`default_nettype none

interface rssm_cmd_if import rssm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CmdW-1:0] cmd;
  logic            mode_value;
  logic [ErrW-1:0] error_value;

  modport source (output valid, cmd, mode_value, error_value, input ready);
  modport sink   (input valid, cmd, mode_value, error_value, output ready);
endinterface

interface rssm_res_if import rssm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [StateW-1:0]  state_now;
  logic [StateW-1:0]  state_before;
  logic               mode_now;
  logic [SafetyW-1:0] safety_now;
  logic               enabled_flag;
  logic               homed_flag;
  logic [ErrW-1:0]    error_now;
  logic               state_changed;
  logic               error_active;
  logic               jog_allowed;
  logic               program_allowed;

  modport source (output valid, accepted, state_now, state_before, mode_now, safety_now,
                  enabled_flag, homed_flag, error_now, state_changed, error_active,
                  jog_allowed, program_allowed, input ready);
  modport sink   (input valid, accepted, state_now, state_before, mode_now, safety_now,
                  enabled_flag, homed_flag, error_now, state_changed, error_active,
                  jog_allowed, program_allowed, output ready);
endinterface

interface rssm_cfg_if import rssm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [TimeoutW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ hdl/robot_supervisor_state_machine_top.sv @@
// channel   dir   payload                                   handshake
// cmd_i     in    cmd, mode_value, error_value              valid / ready
// res_o     out   accepted, status, permission flags        valid / ready
// cfg_i     in    homing timeout ticks (20 bits)            valid / ready, always ready
//
// One command word per cycle unless res_o stalls; input register first, then result register.
// Throughput is set by the update of the supervisor state from the input register.
// rst_ni clears supervisor state and both valid flags; timeout_q resets to HomingTimeoutReset.
// A stalled result holds the input stage once it is full; cmd_i.ready drops only then.
`default_nettype none
`include "assert_macros.svh"

module robot_supervisor_state_machine_top import rssm_pkg::*; #(
  parameter int unsigned TIMER_BITS = TimerBitsDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rssm_cmd_if.sink  cmd_i,
  rssm_cfg_if.sink  cfg_i,
  rssm_res_if.source res_o
);

  localparam int unsigned CmpW = (TIMER_BITS > TimeoutW) ? TIMER_BITS : TimeoutW;

  typedef enum logic [StateW-1:0] {
    StInit    = 4'd0,
    StIdle    = 4'd1,
    StHoming  = 4'd2,
    StReady   = 4'd3,
    StMoving  = 4'd4,
    StExec    = 4'd5,
    StPaused  = 4'd6,
    StError   = 4'd7,
    StEstop   = 4'd8
  } state_e;

  // configuration
  logic [TimeoutW-1:0] timeout_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= HomingTimeoutReset;
    end else if (cfg_i.valid) begin
      timeout_q <= cfg_i.data;
    end
  end

  // input register
  logic            in_valid_q;
  logic [CmdW-1:0] in_cmd_q;
  logic            in_mode_q;
  logic [ErrW-1:0] in_err_q;
  logic            out_valid_q;
  logic            advance;

  assign advance     = in_valid_q && (!out_valid_q || res_o.ready);
  assign cmd_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      in_valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      in_cmd_q  <= cmd_i.cmd;
      in_mode_q <= cmd_i.mode_value;
      in_err_q  <= cmd_i.error_value;
    end
  end

  // supervisor state
  state_e                st_q, st_d, prev_q, prev_d, tgt;
  logic                  mode_q, mode_d;
  logic [SafetyW-1:0]    safety_q, safety_d;
  logic                  en_q, en_d, homed_q, homed_d;
  logic [ErrW-1:0]       err_q, err_d;
  logic [TIMER_BITS-1:0] tis_q, tis_d, tis_inc;
  logic                  acc, go, changed, in_motion, base;

  assign in_motion = (st_q == StMoving) || (st_q == StExec) || (st_q == StHoming);
  assign tis_inc   = (tis_q == '1) ? tis_q : tis_q + 1'b1;

  always_comb begin
    st_d     = st_q;
    prev_d   = prev_q;
    mode_d   = mode_q;
    safety_d = safety_q;
    en_d     = en_q;
    homed_d  = homed_q;
    err_d    = err_q;
    tis_d    = tis_q;
    acc      = 1'b0;
    go       = 1'b0;
    tgt      = st_q;
    changed  = 1'b0;

    case (in_cmd_q)
      CmdEstopPressed: begin
        safety_d = SafeEmerg;
        err_d    = ErrEstop;
        go       = 1'b1;
        tgt      = StEstop;
      end
      CmdDoorOpen: begin
        if (in_motion) begin
          safety_d = SafeProt;
          err_d    = ErrDoorOpen;
          go       = 1'b1;
          tgt      = StError;
        end
      end
      CmdEnable: begin
        if (safety_q == SafeNormal && (st_q == StIdle || st_q == StReady)) begin
          en_d = 1'b1;
          acc  = 1'b1;
        end
      end
      CmdDisable: begin
        en_d = 1'b0;
        acc  = 1'b1;
        if (st_q inside {StReady, StMoving, StExec, StPaused}) begin
          go  = 1'b1;
          tgt = StIdle;
        end
      end
      CmdReset: begin
        if (safety_q != SafeEmerg && (st_q == StError || st_q == StEstop)) begin
          err_d    = ErrNone;
          safety_d = SafeNormal;
          en_d     = 1'b0;
          homed_d  = 1'b0;
          go       = 1'b1;
          tgt      = StIdle;
        end
      end
      CmdSetMode: begin
        if (!in_motion) begin
          mode_d = in_mode_q;
          acc    = 1'b1;
        end
      end
      CmdSetError: begin
        err_d = in_err_q;
        acc   = 1'b1;
      end
      CmdClearError: begin
        if (safety_q != SafeEmerg) begin
          err_d = ErrNone;
          acc   = 1'b1;
        end
      end
      CmdTick: begin
        acc   = 1'b1;
        tis_d = tis_inc;
        if (st_q == StHoming && CmpW'(tis_inc) > CmpW'(timeout_q)) begin
          err_d = ErrHomingTimeout;
          go    = 1'b1;
          tgt   = StError;
        end
      end
      default: ;
    endcase

    if (in_cmd_q == CmdEstopReleased) begin
      safety_d = SafeNormal;
    end

    // transition table; guards see the state before this word
    if (in_cmd_q < CmdEnable && in_cmd_q != CmdEstopPressed &&
        !(in_cmd_q == CmdDoorOpen && in_motion)) begin
      case (st_q)
        StInit: begin
          if (in_cmd_q == CmdInitComplete) begin
            go = 1'b1; tgt = StIdle;
          end
        end
        StIdle: begin
          if (in_cmd_q == CmdEnableRequest) begin
            go = (safety_q == SafeNormal); tgt = StIdle;
          end else if (in_cmd_q == CmdHomeRequest) begin
            go = en_q && (safety_q == SafeNormal); tgt = StHoming;
          end
        end
        StHoming: begin
          if (in_cmd_q == CmdHomeComplete) begin
            go = 1'b1; tgt = StReady;
          end else if (in_cmd_q == CmdHomeError) begin
            go = 1'b1; tgt = StError;
          end else if (in_cmd_q == CmdDisableRequest) begin
            go = 1'b1; tgt = StIdle;
          end
        end
        StReady: begin
          if (in_cmd_q == CmdMotionStart) begin
            go = en_q && homed_q; tgt = StMoving;
          end else if (in_cmd_q == CmdProgramStart) begin
            go = en_q && homed_q && (mode_q == ModeAuto); tgt = StExec;
          end else if (in_cmd_q == CmdDisableRequest) begin
            go = 1'b1; tgt = StIdle;
          end
        end
        StMoving: begin
          if (in_cmd_q == CmdMotionComplete) begin
            go = 1'b1; tgt = StReady;
          end else if (in_cmd_q == CmdMotionError) begin
            go = 1'b1; tgt = StError;
          end else if (in_cmd_q == CmdDisableRequest) begin
            go = 1'b1; tgt = StIdle;
          end
        end
        StExec: begin
          if (in_cmd_q == CmdProgramPause) begin
            go = 1'b1; tgt = StPaused;
          end else if (in_cmd_q == CmdProgramComplete || in_cmd_q == CmdProgramStop) begin
            go = 1'b1; tgt = StReady;
          end else if (in_cmd_q == CmdProgramError) begin
            go = 1'b1; tgt = StError;
          end else if (in_cmd_q == CmdMotionStart || in_cmd_q == CmdMotionComplete) begin
            go = 1'b1; tgt = StExec;
          end
        end
        StPaused: begin
          if (in_cmd_q == CmdProgramResume) begin
            go = 1'b1; tgt = StExec;
          end else if (in_cmd_q == CmdProgramStop) begin
            go = 1'b1; tgt = StReady;
          end else if (in_cmd_q == CmdDisableRequest) begin
            go = 1'b1; tgt = StIdle;
          end
        end
        StError: begin
          if (in_cmd_q == CmdResetRequest || in_cmd_q == CmdErrorCleared) begin
            go = (safety_q != SafeEmerg); tgt = StIdle;
          end
        end
        StEstop: begin
          if (in_cmd_q == CmdEstopReleased) begin
            go = 1'b1; tgt = StError;
          end else if (in_cmd_q == CmdResetRequest) begin
            go = (safety_q == SafeNormal); tgt = StIdle;
          end
        end
        default: ;
      endcase
    end

    if (go) begin
      acc = 1'b1;
      if (tgt != st_q) begin
        prev_d  = st_q;
        st_d    = tgt;
        tis_d   = '0;
        changed = 1'b1;
        if (tgt == StIdle || tgt == StError || tgt == StEstop) begin
          en_d = 1'b0;
        end
        if (tgt == StReady) begin
          homed_d = 1'b1;
        end
      end
    end
  end

  assign base = en_d && homed_d && (safety_d == SafeNormal) && (st_d == StReady);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StInit;
      prev_q   <= StInit;
      mode_q   <= ModeManual;
      safety_q <= SafeNormal;
      en_q     <= 1'b0;
      homed_q  <= 1'b0;
      err_q    <= ErrNone;
      tis_q    <= '0;
    end else if (advance) begin
      st_q     <= st_d;
      prev_q   <= prev_d;
      mode_q   <= mode_d;
      safety_q <= safety_d;
      en_q     <= en_d;
      homed_q  <= homed_d;
      err_q    <= err_d;
      tis_q    <= tis_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_o.accepted        <= acc;
      res_o.state_now       <= StateW'(st_d);
      res_o.state_before    <= StateW'(prev_d);
      res_o.mode_now        <= mode_d;
      res_o.safety_now      <= safety_d;
      res_o.enabled_flag    <= en_d;
      res_o.homed_flag      <= homed_d;
      res_o.error_now       <= err_d;
      res_o.state_changed   <= changed;
      res_o.error_active    <= (st_d == StError) || (st_d == StEstop) || (err_d != ErrNone);
      res_o.jog_allowed     <= base && (mode_d == ModeManual);
      res_o.program_allowed <= base && (mode_d == ModeAuto);
    end
  end

  assign res_o.valid = out_valid_q;

  `ASSERT_PROP(a_changed_differs,
    (res_o.valid && res_o.state_changed) |-> (res_o.state_now != res_o.state_before),
    "state_changed set without a new state")
  `ASSERT_PROP(a_state_only_on_advance,
    (st_q != $past(st_q)) |-> $past(advance), "state moved without a command word")
  `ASSERT_PROP(a_estop_is_emergency,
    (st_q == StEstop) |-> (safety_q == SafeEmerg), "estop state without emergency safety")
  `ASSERT_PROP(a_permission_needs_ready,
    (res_o.valid && (res_o.jog_allowed || res_o.program_allowed)) |->
      (res_o.enabled_flag && res_o.homed_flag && res_o.state_now == StateW'(StReady)),
    "permission given outside an enabled, homed ready state")
  `ASSERT_NEVER(a_no_overwrite, out_valid_q && !res_o.ready && advance,
    "result word overwritten while stalled")

endmodule

`default_nettype wire

@@ bench/robot_supervisor_state_machine_top_test.sv @@
`timescale 1ns / 100ps

module robot_supervisor_state_machine_top_test;
  import rssm_pkg::*;

  localparam int unsigned TimerBits = TimerBitsDefault;
  localparam logic [63:0] TickMax = (64'd1 << TimerBits) - 64'd1;
  localparam logic [CmdW-1:0] CmdUnusedLast = 5'd31;
  localparam int unsigned ItemsPerPhase = 400;

  typedef enum logic [StateW-1:0] {
    StInit, StIdle, StHoming, StReady, StMoving, StExec, StPaused, StError, StEstop
  } arm_state_e;

  typedef enum {GdNone, GdSafe, GdEnSafe, GdEnHomed, GdEnHomedAuto, GdNotEstop} guard_e;

  typedef enum {JobCmd, JobCfg} job_e;

  typedef struct {
    logic       hit;
    arm_state_e dest;
    guard_e     gd;
  } rule_t;

  typedef struct {
    job_e                kind;
    logic [CmdW-1:0]     cmd;
    logic                mode_value;
    logic [ErrW-1:0]     error_value;
    logic [TimeoutW-1:0] timeout;
  } plan_item_t;

  typedef struct {
    logic               accepted;
    logic [StateW-1:0]  state_now;
    logic [StateW-1:0]  state_before;
    logic               mode_now;
    logic [SafetyW-1:0] safety_now;
    logic               enabled_flag;
    logic               homed_flag;
    logic [ErrW-1:0]    error_now;
    logic               state_changed;
    logic               error_active;
    logic               jog_allowed;
    logic               program_allowed;
  } status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rssm_cmd_if cmd_ch ();
  rssm_cfg_if cfg_ch ();
  rssm_res_if res_ch ();

  robot_supervisor_state_machine_top uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cmd_i (cmd_ch),
    .cfg_i (cfg_ch),
    .res_o (res_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // supervisor shadow state, starts at reset values
  arm_state_e          arm_st = StInit;
  arm_state_e          arm_prev = StInit;
  logic                arm_mode = ModeManual;
  logic [SafetyW-1:0]  arm_safety = SafeNormal;
  logic                arm_enabled = 1'b0;
  logic                arm_homed = 1'b0;
  logic [ErrW-1:0]     arm_err = ErrNone;
  logic [63:0]         arm_ticks = '0;
  logic                arm_moved = 1'b0;
  logic [TimeoutW-1:0] homing_limit = HomingTimeoutReset;

  plan_item_t cmd_plan[$];
  status_t    pending_status[$];
  int         busy_items = 0;
  int         mismatches = 0;
  int         send_wait = 0;
  int         send_calm = 0;
  int         recv_hold = 0;
  int         recv_calm = 0;

  function automatic logic moving_phase();
    return arm_st == StHoming || arm_st == StMoving || arm_st == StExec;
  endfunction

  function automatic logic move_to(arm_state_e dest);
    if (dest != arm_st) begin
      arm_prev = arm_st;
      arm_st = dest;
      arm_ticks = '0;
      arm_moved = 1'b1;
      if (dest == StIdle || dest == StError || dest == StEstop) arm_enabled = 1'b0;
      if (dest == StReady) arm_homed = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic rule_t find_rule(arm_state_e from, logic [CmdW-1:0] ev);
    rule_t r;
    r.hit = 1'b1;
    r.dest = from;
    r.gd = GdNone;
    case (from)
      StInit: begin
        if (ev == CmdInitComplete) r.dest = StIdle;
        else r.hit = 1'b0;
      end
      StIdle: begin
        if (ev == CmdEnableRequest) r.gd = GdSafe;
        else if (ev == CmdHomeRequest) begin
          r.dest = StHoming;
          r.gd = GdEnSafe;
        end else r.hit = 1'b0;
      end
      StHoming: begin
        if (ev == CmdHomeComplete) r.dest = StReady;
        else if (ev == CmdHomeError) r.dest = StError;
        else if (ev == CmdDisableRequest) r.dest = StIdle;
        else r.hit = 1'b0;
      end
      StReady: begin
        if (ev == CmdMotionStart) begin
          r.dest = StMoving;
          r.gd = GdEnHomed;
        end else if (ev == CmdProgramStart) begin
          r.dest = StExec;
          r.gd = GdEnHomedAuto;
        end else if (ev == CmdDisableRequest) r.dest = StIdle;
        else r.hit = 1'b0;
      end
      StMoving: begin
        if (ev == CmdMotionComplete) r.dest = StReady;
        else if (ev == CmdMotionError) r.dest = StError;
        else if (ev == CmdDisableRequest) r.dest = StIdle;
        else r.hit = 1'b0;
      end
      StExec: begin
        if (ev == CmdProgramPause) r.dest = StPaused;
        else if (ev == CmdProgramComplete || ev == CmdProgramStop) r.dest = StReady;
        else if (ev == CmdProgramError) r.dest = StError;
        else if (ev != CmdMotionStart && ev != CmdMotionComplete) r.hit = 1'b0;
      end
      StPaused: begin
        if (ev == CmdProgramResume) r.dest = StExec;
        else if (ev == CmdProgramStop) r.dest = StReady;
        else if (ev == CmdDisableRequest) r.dest = StIdle;
        else r.hit = 1'b0;
      end
      StError: begin
        if (ev == CmdResetRequest || ev == CmdErrorCleared) begin
          r.dest = StIdle;
          r.gd = GdNotEstop;
        end else r.hit = 1'b0;
      end
      StEstop: begin
        if (ev == CmdEstopReleased) r.dest = StError;
        else if (ev == CmdResetRequest) begin
          r.dest = StIdle;
          r.gd = GdSafe;
        end else r.hit = 1'b0;
      end
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic guard_pass(guard_e g);
    case (g)
      GdSafe:        return arm_safety == SafeNormal;
      GdEnSafe:      return arm_enabled && arm_safety == SafeNormal;
      GdEnHomed:     return arm_enabled && arm_homed;
      GdEnHomedAuto: return arm_enabled && arm_homed && arm_mode == ModeAuto;
      GdNotEstop:    return arm_safety != SafeEmerg;
      default:       return 1'b1;
    endcase
  endfunction

  function automatic logic apply_event(logic [CmdW-1:0] ev);
    rule_t r;
    if (ev == CmdEstopPressed) begin
      arm_safety = SafeEmerg;
      arm_err = ErrEstop;
      return move_to(StEstop);
    end
    // release clears safety even if no rule then matches
    if (ev == CmdEstopReleased) arm_safety = SafeNormal;
    if (ev == CmdDoorOpen && moving_phase()) begin
      arm_safety = SafeProt;
      arm_err = ErrDoorOpen;
      return move_to(StError);
    end
    r = find_rule(arm_st, ev);
    if (!r.hit || !guard_pass(r.gd)) return 1'b0;
    return move_to(r.dest);
  endfunction

  function automatic status_t supervise(logic [CmdW-1:0] c, logic mv, logic [ErrW-1:0] ev);
    status_t s;
    logic    ok;
    logic    base;
    ok = 1'b0;
    arm_moved = 1'b0;
    if (c < CmdEnable) ok = apply_event(c);
    else begin
      case (c)
        CmdEnable: begin
          if (arm_safety == SafeNormal && (arm_st == StIdle || arm_st == StReady)) begin
            arm_enabled = 1'b1;
            ok = 1'b1;
          end
        end
        CmdDisable: begin
          arm_enabled = 1'b0;
          ok = 1'b1;
          if (arm_st == StReady || arm_st == StMoving || arm_st == StExec ||
              arm_st == StPaused)
            ok = move_to(StIdle);
        end
        CmdReset: begin
          if (arm_safety != SafeEmerg && (arm_st == StError || arm_st == StEstop)) begin
            arm_err = ErrNone;
            arm_safety = SafeNormal;
            arm_enabled = 1'b0;
            arm_homed = 1'b0;
            ok = move_to(StIdle);
          end
        end
        CmdSetMode: begin
          if (!moving_phase()) begin
            arm_mode = mv;
            ok = 1'b1;
          end
        end
        CmdSetError: begin
          arm_err = ev;
          ok = 1'b1;
        end
        CmdClearError: begin
          if (arm_safety != SafeEmerg) begin
            arm_err = ErrNone;
            ok = 1'b1;
          end
        end
        CmdTick: begin
          // saturating count first, then the homing timeout test
          if (arm_ticks < TickMax) arm_ticks++;
          if (arm_st == StHoming && arm_ticks > {44'd0, homing_limit}) begin
            arm_err = ErrHomingTimeout;
            void'(move_to(StError));
          end
          ok = 1'b1;
        end
        default: ok = 1'b0;
      endcase
    end
    base = arm_enabled && arm_homed && arm_safety == SafeNormal && arm_st == StReady;
    s.accepted = ok;
    s.state_now = arm_st;
    s.state_before = arm_prev;
    s.mode_now = arm_mode;
    s.safety_now = arm_safety;
    s.enabled_flag = arm_enabled;
    s.homed_flag = arm_homed;
    s.error_now = arm_err;
    s.state_changed = arm_moved;
    s.error_active = arm_st == StError || arm_st == StEstop || arm_err != ErrNone;
    s.jog_allowed = base && arm_mode == ModeManual;
    s.program_allowed = base && arm_mode == ModeAuto;
    return s;
  endfunction

  // per-word idle draw, with occasional stretches of back-to-back words
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  task automatic push_cmd(input logic [CmdW-1:0] c, input int mv = -1, input int ev = -1);
    plan_item_t p;
    p.kind = JobCmd;
    p.cmd = c;
    p.mode_value = (mv < 0) ? 1'($urandom) : 1'(mv);
    p.error_value = (ev < 0) ? ErrW'($urandom) : ErrW'(ev);
    p.timeout = '0;
    cmd_plan.insert(cmd_plan.size(), p);
    if (c <= CmdTick) busy_items++;
  endtask

  // timeout writes wait in the driver until every pending result is back
  task automatic push_cfg(input logic [TimeoutW-1:0] value);
    plan_item_t p;
    p.kind = JobCfg;
    p.cmd = CmdInitComplete;
    p.mode_value = 1'b0;
    p.error_value = ErrNone;
    p.timeout = value;
    cmd_plan.insert(cmd_plan.size(), p);
  endtask

  task automatic add_random_flow();
    int pick;
    int n;
    pick = $urandom_range(0, 9);
    if ($urandom_range(0, 3) != 0) begin
      // walks any state back to idle with safety normal
      push_cmd(CmdInitComplete);
      push_cmd(CmdDisable);
      push_cmd(CmdDisableRequest);
      push_cmd(CmdEstopReleased);
      push_cmd(CmdReset);
    end
    case (pick)
      0, 1, 2, 3, 4, 5: begin
        push_cmd(CmdSetMode, (pick < 3) ? int'($urandom_range(0, 7) == 0) :
                                          int'($urandom_range(0, 7) != 0));
        push_cmd(CmdEnable);
        if ($urandom_range(0, 3) == 0) push_cmd(CmdEnableRequest);
        push_cmd(CmdHomeRequest);
        repeat ($urandom_range(0, 4)) push_cmd(CmdTick);
        push_cmd(($urandom_range(0, 7) == 0) ? CmdHomeError : CmdHomeComplete);
        if (pick < 3) begin
          n = $urandom_range(1, 4);
          repeat (n) begin
            push_cmd(CmdMotionStart);
            repeat ($urandom_range(0, 2)) push_cmd(CmdTick);
            if ($urandom_range(0, 5) == 0) push_cmd(CmdSetMode);
            case ($urandom_range(0, 9))
              0, 1, 2, 3, 4, 5: push_cmd(CmdMotionComplete);
              6: push_cmd(CmdMotionError);
              7: push_cmd(CmdDoorOpen);
              8: push_cmd(CmdEstopPressed);
              default: push_cmd(($urandom_range(0, 1) != 0) ? CmdDisable : CmdDisableRequest);
            endcase
          end
        end else begin
          push_cmd(CmdProgramStart);
          n = $urandom_range(1, 5);
          repeat (n) begin
            case ($urandom_range(0, 5))
              0: push_cmd(CmdProgramPause);
              1: push_cmd(CmdProgramResume);
              2: push_cmd(CmdMotionStart);
              3: push_cmd(CmdMotionComplete);
              4: push_cmd(CmdTick);
              default: push_cmd(CmdSetMode);
            endcase
          end
          case ($urandom_range(0, 7))
            0, 1: push_cmd(CmdProgramComplete);
            2, 3: push_cmd(CmdProgramStop);
            4: push_cmd(CmdProgramError);
            5: push_cmd(CmdDoorOpen);
            6: push_cmd(CmdEstopPressed);
            default: push_cmd(CmdDisable);
          endcase
        end
      end
      6: begin
        push_cmd(CmdSetError);
        push_cmd(($urandom_range(0, 1) != 0) ? CmdClearError : CmdErrorCleared);
        push_cmd(CmdHomeError);
        push_cmd(($urandom_range(0, 1) != 0) ? CmdReset : CmdResetRequest);
      end
      7: begin
        push_cmd(CmdEstopPressed);
        repeat ($urandom_range(0, 3)) begin
          case ($urandom_range(0, 3))
            0: push_cmd(CmdClearError);
            1: push_cmd(CmdReset);
            2: push_cmd(CmdResetRequest);
            default: push_cmd(CmdTick);
          endcase
        end
        push_cmd(CmdEstopReleased);
        case ($urandom_range(0, 2))
          0: push_cmd(CmdReset);
          1: push_cmd(CmdResetRequest);
          default: push_cmd(CmdErrorCleared);
        endcase
      end
      default: begin
        repeat ($urandom_range(3, 8)) push_cmd(CmdW'($urandom_range(0, 31)));
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : drive_proc
    plan_item_t nxt;
    logic       cmd_busy;
    logic       cfg_busy;
    logic       load_cmd;
    logic       load_cfg;
    if (!rst_n) begin
      cmd_ch.valid <= 1'b0;
      cfg_ch.valid <= 1'b0;
    end else begin
      cmd_busy = cmd_ch.valid;
      cfg_busy = cfg_ch.valid;
      load_cmd = 1'b0;
      load_cfg = 1'b0;
      if (cmd_ch.valid && cmd_ch.ready) begin
        pending_status.insert(pending_status.size(),
                              supervise(cmd_ch.cmd, cmd_ch.mode_value, cmd_ch.error_value));
        cmd_busy = 1'b0;
        send_wait = draw_wait(send_calm);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        homing_limit = cfg_ch.data;
        cfg_busy = 1'b0;
      end
      if (!cmd_busy && !cfg_busy && cmd_plan.size() != 0) begin
        nxt = cmd_plan[0];
        if (send_wait > 0) send_wait--;
        else if (nxt.kind == JobCmd) begin
          load_cmd = 1'b1;
          cmd_plan.delete(0);
        end else if (pending_status.size() == 0) begin
          load_cfg = 1'b1;
          cmd_plan.delete(0);
        end
      end
      cmd_ch.valid <= cmd_busy | load_cmd;
      cfg_ch.valid <= cfg_busy | load_cfg;
      if (load_cmd) begin
        cmd_ch.cmd <= nxt.cmd;
        cmd_ch.mode_value <= nxt.mode_value;
        cmd_ch.error_value <= nxt.error_value;
      end
      if (load_cfg) cfg_ch.data <= nxt.timeout;
    end
  end

  always @(posedge clk) begin : watch_proc
    status_t want;
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (pending_status.size() == 0) begin
          $display("%0t ns: result word with nothing pending, state %0d accepted %0d",
                   $time, res_ch.state_now, res_ch.accepted);
          mismatches++;
        end else begin
          want = pending_status.pop_front();
          compare_field("accepted", want.accepted, res_ch.accepted);
          compare_field("state_now", want.state_now, res_ch.state_now);
          compare_field("state_before", want.state_before, res_ch.state_before);
          compare_field("mode_now", want.mode_now, res_ch.mode_now);
          compare_field("safety_now", want.safety_now, res_ch.safety_now);
          compare_field("enabled_flag", want.enabled_flag, res_ch.enabled_flag);
          compare_field("homed_flag", want.homed_flag, res_ch.homed_flag);
          compare_field("error_now", want.error_now, res_ch.error_now);
          compare_field("state_changed", want.state_changed, res_ch.state_changed);
          compare_field("error_active", want.error_active, res_ch.error_active);
          compare_field("jog_allowed", want.jog_allowed, res_ch.jog_allowed);
          compare_field("program_allowed", want.program_allowed, res_ch.program_allowed);
        end
        recv_hold = draw_wait(recv_calm);
      end else if (recv_hold > 0) begin
        recv_hold--;
      end
      res_ch.ready <= (recv_hold == 0);
    end
  end

  initial begin : stim_proc
    logic [TimeoutW-1:0] limits[4];
    int                  target;
    cmd_ch.valid = 1'b0;
    cmd_ch.cmd = CmdInitComplete;
    cmd_ch.mode_value = ModeManual;
    cmd_ch.error_value = ErrNone;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    res_ch.ready = 1'b0;

    // directed walk with the reset timeout
    push_cmd(CmdTick);
    push_cmd(CmdUnusedLast);
    push_cmd(CmdInitComplete);
    push_cmd(CmdEnableRequest);
    push_cmd(CmdSetMode, ModeAuto);
    push_cmd(CmdEnable);
    push_cmd(CmdHomeRequest);
    push_cmd(CmdSetMode, ModeManual);
    push_cmd(CmdDoorOpen);
    push_cmd(CmdErrorCleared);
    push_cmd(CmdSetError, -1, 255);
    push_cmd(CmdClearError);
    push_cmd(CmdEnable);
    push_cmd(CmdHomeRequest);
    push_cmd(CmdHomeComplete);
    push_cmd(CmdProgramStart);
    push_cmd(CmdMotionStart);
    push_cmd(CmdProgramPause);
    push_cmd(CmdProgramResume);
    push_cmd(CmdEstopPressed);
    push_cmd(CmdClearError);
    push_cmd(CmdReset);
    push_cmd(CmdEstopReleased);
    push_cmd(CmdReset);
    push_cmd(CmdDoorOpen);
    // timeout of one: second tick in homing trips it
    push_cfg(TimeoutW'(1));
    push_cmd(CmdEnable);
    push_cmd(CmdHomeRequest);
    push_cmd(CmdTick);
    push_cmd(CmdTick);

    limits[0] = TimeoutW'($urandom_range(2, 6));
    limits[1] = '1;
    limits[2] = TimeoutW'($urandom_range(1, 1048575));
    limits[3] = TimeoutW'(1);
    foreach (limits[i]) begin
      push_cfg(limits[i]);
      target = busy_items + ItemsPerPhase;
      while (busy_items < target) add_random_flow();
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (cmd_plan.size() != 0 || cmd_ch.valid || cfg_ch.valid || pending_status.size() != 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("robot_supervisor_state_machine_top regression: pass");
    end else begin
      $display("robot_supervisor_state_machine_top regression: fail");
    end
    $finish;
  end

  initial begin : watchdog_proc
    #2000000;
    $display("robot_supervisor_state_machine_top regression: fail");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/rssm_pkg.sv
hdl/rssm_if.sv
hdl/robot_supervisor_state_machine_top.sv
bench/robot_supervisor_state_machine_top_test.sv
